// ----- hdl/box_filter_mipmap_chain_unit_assert.svh -----
// Assertion macros for the mipmap chain RTL, used by bfmc_back.
// Needs a clock named clk and an active-high reset named rst in scope.
`ifndef BOX_FILTER_MIPMAP_CHAIN_UNIT_ASSERT_SVH
`define BOX_FILTER_MIPMAP_CHAIN_UNIT_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define BFMC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define BFMC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/bfmc_pkg.sv -----
// Shared types and constants for the mipmap chain unit.
// No dependencies.
package bfmc_pkg;

  localparam int SIDE_W  = 13;  // image side register width
  localparam int COORD_W = 12;  // col/row result fields
  localparam int LEVEL_W = 4;   // level result field
  localparam int CH_W    = 8;   // one color channel
  localparam int SUM_W   = 10;  // one channel of a 2x2 sum
  localparam int NCH     = 4;   // red, green, blue, alpha

  localparam int IN_W  = 32;
  localparam int OUT_W = 64;

  localparam int DEF_MAX_SIDE   = 4096;
  localparam int DEF_MAX_LEVELS = 13;
  localparam int QUEUE_DEPTH    = 4;

  localparam logic [SIDE_W-1:0] RESET_SIDE = 13'd256;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;

  typedef logic [NCH-1:0][CH_W-1:0]  pixel_t;  // lane 0 = red
  typedef logic [NCH-1:0][SUM_W-1:0] sums_t;

  typedef struct packed {
    pixel_t            px;
    logic [SIDE_W-1:0] x;
    logic [SIDE_W-1:0] y;
    logic              final_px;
  } item_t;

  typedef struct packed {
    logic [SIDE_W-1:0] width;
    logic [SIDE_W-1:0] height;
    logic              clear;   // restart image, counters to zero
  } cfg_t;

  typedef enum logic {
    BK_IDLE,
    BK_LEVEL
  } bk_state_t;

endpackage

// ----- hdl/bfmc_front.sv -----
// Front end: accepts base pixels and tags them with their level 0 position.
// Depends on bfmc_pkg.
module bfmc_front import bfmc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [IN_W-1:0]   s_tdata,
  input  logic              q_full,
  output logic              push,
  output item_t             item
);

  logic [SIDE_W-1:0] col;
  logic [SIDE_W-1:0] row;
  logic              col_end;
  logic              row_end;

  assign s_tready = !q_full;
  assign push     = s_tvalid && !q_full;
  assign col_end  = (col == cfg.width - SIDE_W'(1));
  assign row_end  = (row == cfg.height - SIDE_W'(1));

  always_comb begin
    item.px       = pixel_t'(s_tdata);
    item.x        = col;
    item.y        = row;
    item.final_px = col_end && row_end;
  end

  always_ff @(posedge clk) begin
    if (rst || cfg.clear) begin
      col <= '0;
      row <= '0;
    end else if (push) begin
      if (col_end) begin
        col <= '0;
        row <= row_end ? '0 : row + SIDE_W'(1);
      end else begin
        col <= col + SIDE_W'(1);
      end
    end
  end

endmodule

// ----- hdl/bfmc_queue.sv -----
// Short item queue between front end and level sequencer.
// Depends on bfmc_pkg.
module bfmc_queue import bfmc_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t wr_item,
  output logic  full,
  output logic  valid,
  output item_t rd_item,
  input  logic  pop
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  item_t          slots [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign full    = (count == CW'(DEPTH));
  assign valid   = (count != '0);
  assign rd_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_item;
    end
  end

endmodule

// ----- hdl/bfmc_back.sv -----
// Level sequencer: one result per cycle unless stalled; walks an item's levels.
// Depends on bfmc_pkg and the assertion macro header.
`include "box_filter_mipmap_chain_unit_assert.svh"

module bfmc_back import bfmc_pkg::*; #(
  parameter int MAX_SIDE   = DEF_MAX_SIDE,
  parameter int MAX_LEVELS = DEF_MAX_LEVELS
) (
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  logic             q_valid,
  input  item_t            q_item,
  output logic             pop,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,
  output logic             m_tlast,
  output logic             m_tuser
);

  localparam int AW  = $clog2(MAX_SIDE);
  localparam int IXW = $clog2(MAX_LEVELS);

  bk_state_t          state;
  bk_state_t          state_next;
  logic [LEVEL_W-1:0] lv_reg;
  logic [SIDE_W-1:0]  off_reg;
  sums_t              pair_reg;
  sums_t              rdata;
  logic               final_reg;

  sums_t              held_sums     [MAX_LEVELS];
  logic [SIDE_W-1:0]  level_col     [MAX_LEVELS];
  logic [SIDE_W-1:0]  level_row     [MAX_LEVELS];
  sums_t              pair_sum_rows [MAX_SIDE];

  logic               adv;
  logic               fire;
  logic [LEVEL_W-1:0] cur_lv;
  logic [SIDE_W-1:0]  cur_x;
  logic [SIDE_W-1:0]  cur_y;
  sums_t              cur_val;
  logic               cur_final;
  sums_t              total;
  logic [SIDE_W-1:0]  lw;
  logic [SIDE_W-1:0]  lh;
  logic [LEVEL_W-1:0] s_lv;
  logic [SIDE_W-1:0]  s_off;
  logic [SIDE_W-1:0]  s_w;
  logic [SIDE_W-1:0]  s_h;
  logic               in_range;
  sums_t              held_rd;
  sums_t              pair;
  logic [AW-1:0]      idx;
  logic               do_hold;
  logic               do_wr;
  logic               go_on;
  logic [IXW-1:0]     cur_ix;
  logic [IXW-1:0]     s_ix;

  assign adv    = !m_tvalid || m_tready;
  assign fire   = adv && ((state == BK_LEVEL) || q_valid);
  assign pop    = adv && (state == BK_IDLE) && q_valid;
  assign cur_ix = lv_reg[IXW-1:0];

  // Current result: the base pixel, or the finished 2x2 mean of level lv_reg.
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      total[c] = rdata[c] + pair_reg[c];
    end
    if (state == BK_IDLE) begin
      cur_lv    = '0;
      cur_x     = q_item.x;
      cur_y     = q_item.y;
      cur_final = q_item.final_px;
      s_off     = '0;
      for (int c = 0; c < NCH; c++) begin
        cur_val[c] = {2'b00, q_item.px[c]};
      end
    end else begin
      cur_lv    = lv_reg;
      cur_x     = level_col[cur_ix];
      cur_y     = level_row[cur_ix];
      cur_final = final_reg;
      s_off     = off_reg;
      for (int c = 0; c < NCH; c++) begin
        cur_val[c] = {2'b00, total[c][SUM_W-1:2]};
      end
    end
  end

  // Step into the next level with the current pixel as a source.
  always_comb begin
    s_lv     = cur_lv + LEVEL_W'(1);
    s_ix     = s_lv[IXW-1:0];
    s_w      = cfg.width >> s_lv;
    s_h      = cfg.height >> s_lv;
    lw       = cfg.width >> cur_lv;
    lh       = cfg.height >> cur_lv;
    in_range = (32'(s_lv) < MAX_LEVELS) && (s_w != '0) && (s_h != '0) &&
               ({1'b0, cur_x} < {s_w, 1'b0}) && ({1'b0, cur_y} < {s_h, 1'b0});
    held_rd  = held_sums[s_ix];
    for (int c = 0; c < NCH; c++) begin
      pair[c] = held_rd[c] + cur_val[c];
    end
    idx     = AW'(s_off) + AW'(cur_x >> 1);
    do_hold = fire && in_range && !cur_x[0];
    do_wr   = fire && in_range && cur_x[0] && !cur_y[0];
    go_on   = in_range && cur_x[0] && cur_y[0];
    state_next = state;
    if (fire) begin
      state_next = go_on ? BK_LEVEL : BK_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    state <= rst ? BK_IDLE : state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg.clear) begin
      for (int i = 0; i < MAX_LEVELS; i++) begin
        level_col[i] <= '0;
        level_row[i] <= '0;
      end
    end else if (fire && (state == BK_LEVEL)) begin
      if (level_col[cur_ix] == lw - SIDE_W'(1)) begin
        level_col[cur_ix] <= '0;
        level_row[cur_ix] <= (level_row[cur_ix] == lh - SIDE_W'(1)) ?
                             '0 : level_row[cur_ix] + SIDE_W'(1);
      end else begin
        level_col[cur_ix] <= level_col[cur_ix] + SIDE_W'(1);
      end
    end
  end

  // Result register and per-item context.
  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= {4'b0000,
                  cur_val[3][CH_W-1:0], cur_val[2][CH_W-1:0],
                  cur_val[1][CH_W-1:0], cur_val[0][CH_W-1:0],
                  cur_y[COORD_W-1:0], cur_x[COORD_W-1:0], cur_lv};
      m_tlast <= !go_on;
      m_tuser <= !go_on && cur_final;
      if (go_on) begin
        pair_reg  <= pair;
        lv_reg    <= s_lv;
        off_reg   <= s_off + s_w;
        final_reg <= cur_final;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_hold) begin
      held_sums[s_ix] <= cur_val;
    end
  end

  // Row buffer of horizontal pair sums, packed by level.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      pair_sum_rows[idx] <= pair;
    end
    if (fire && go_on) begin
      rdata <= pair_sum_rows[idx];
    end
  end

  `BFMC_ASSERT_SAME(a_level_range, state == BK_LEVEL,
                    lv_reg != '0 && 32'(lv_reg) < MAX_LEVELS, "mip level out of range")
  `BFMC_ASSERT_NEXT(a_base_first, fire && state == BK_IDLE,
                    m_tdata[LEVEL_W-1:0] == '0, "item did not start with base level")
  `BFMC_ASSERT_NEXT(a_last_ends, fire && !go_on,
                    state == BK_IDLE && m_tlast, "last result did not end the item")
  `BFMC_ASSERT_SAME(a_done_last, m_tvalid && m_tuser,
                    m_tlast, "image end flagged on a non-final result")

endmodule

// ----- hdl/box_filter_mipmap_chain_unit.sv -----
// Streaming 2x2 box-filter mipmap chain, top level.
// Depends on bfmc_pkg, bfmc_front, bfmc_queue and bfmc_back.
//
// Usage:
//   Base RGBA8 pixels enter on the s_ group in row-major order, one item each.
//   Every pixel comes back on the m_ group as a level 0 item; each completed
//   2x2 block of a level L-1 produces a level L item right after it, levels
//   ascending. m_tlast marks the final item caused by one input pixel and
//   m_tuser marks the final item of the whole image.
//   Image size is written on the cfg_ port (index 0 width, 1 height) while
//   the block is idle; a write restarts the image at pixel zero.
// Timing:
//   An accepted input is written into the queue and reaches m_tvalid through
//   the output register once the sequencer takes it; a busy sequencer or a
//   stalled output can hold it in the queue. The level sequencer emits one
//   result per cycle while m_tready does not stall it; an input yields about
//   1.33 results on average. A four-entry queue absorbs bursts of extra
//   results; under sustained input s_tready drops whenever the queue fills.
// Reset and stall:
//   rst clears position counters, the queue and the output register; the
//   size registers return to 256 x 256. The row sum buffer needs no clear.
//   While m_tvalid is high and m_tready low the output holds and the
//   front keeps accepting until the queue fills.
module box_filter_mipmap_chain_unit import bfmc_pkg::*; #(
  parameter int MAX_SIDE   = DEF_MAX_SIDE,
  parameter int MAX_LEVELS = DEF_MAX_LEVELS
) (
  input  logic                 clk,
  input  logic                 rst,
  // config write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIDE_W-1:0]    cfg_data,
  // input pixels
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [IN_W-1:0]      s_tdata,   // red[7:0], green[15:8], blue[23:16], alpha[31:24]
  // results
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [OUT_W-1:0]     m_tdata,   // level[3:0], col[15:4], row[27:16], red[35:28],
                                          // green[43:36], blue[51:44], alpha[59:52], zero pad
  output logic                 m_tlast,
  output logic                 m_tuser    // image_done[0]
);

  logic [SIDE_W-1:0] image_width;
  logic [SIDE_W-1:0] image_height;
  logic [SIDE_W-1:0] side_clamped;
  cfg_t              cfg;

  logic  push;
  logic  q_full;
  logic  q_valid;
  logic  pop;
  item_t wr_item;
  item_t rd_item;

  // Size written as 0 means 1; oversize saturates at the row buffer depth.
  always_comb begin
    side_clamped = cfg_data;
    if (cfg_data == '0) begin
      side_clamped = SIDE_W'(1);
    end else if (32'(cfg_data) > MAX_SIDE) begin
      side_clamped = SIDE_W'(MAX_SIDE);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RESET_SIDE;
      image_height <= RESET_SIDE;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  image_width  <= side_clamped;
        CFG_IMAGE_HEIGHT: image_height <= side_clamped;
        default: ;
      endcase
    end
  end

  // Any write restarts the image.
  assign cfg.width  = image_width;
  assign cfg.height = image_height;
  assign cfg.clear  = cfg_we;

  bfmc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_full   (q_full),
    .push     (push),
    .item     (wr_item)
  );

  bfmc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_item (wr_item),
    .full    (q_full),
    .valid   (q_valid),
    .rd_item (rd_item),
    .pop     (pop)
  );

  bfmc_back #(
    .MAX_SIDE   (MAX_SIDE),
    .MAX_LEVELS (MAX_LEVELS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_item   (rd_item),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

// ----- test/tb_box_filter_mipmap_chain_unit.sv -----
`timescale 1ns / 1ps
// Self-checking bench for box_filter_mipmap_chain_unit: streams RGBA8 images of many
// sizes through the unit and checks every mip level item against a local 2x2 box model.
// Depends on bfmc_pkg and the unit's RTL.
module tb_box_filter_mipmap_chain_unit;
  import bfmc_pkg::*;

  localparam int WATCHDOG_CYCLES = 2000;  // cycles with no item moving on either side
  localparam int DRAIN_CYCLES    = 20;    // queue + output register, with margin
  localparam int RANDOM_ITEMS    = 190;
  localparam int MAX_REPORTS     = 10;

  typedef enum int {
    IDLE_NONE,
    IDLE_SRC,
    IDLE_SNK,
    IDLE_BOTH
  } idle_mode_t;

  // one result item, laid out field by field
  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    pixel_t             px;
    logic [3:0]         pad;
    logic               last;
    logic               done;
  } mip_px_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_IMAGE_WIDTH;
  logic [SIDE_W-1:0]    cfg_data = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [IN_W-1:0]      s_tdata = '0;  // red[7:0], green[15:8], blue[23:16], alpha[31:24]
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [OUT_W-1:0]     m_tdata;       // level, col, row, red, green, blue, alpha, zero pad
  logic                 m_tlast;
  logic                 m_tuser;       // image_done

  box_filter_mipmap_chain_unit dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Mip chain model: own copy of the size registers and per-level state.
  // ---------------------------------------------------------------------------
  int unsigned cur_w;
  int unsigned cur_h;
  sums_t       even_row_pairs [DEF_MAX_SIDE];    // pair sums of even rows, packed by level
  sums_t       left_px        [DEF_MAX_LEVELS];  // even-column source pixel per level
  int unsigned next_col       [DEF_MAX_LEVELS];
  int unsigned next_row       [DEF_MAX_LEVELS];

  mip_px_t     mip_expected [$];
  pixel_t      pix_pending  [$];
  idle_mode_t  idle_mode = IDLE_NONE;
  logic        pix_took = 1'b0;   // input item accepted at the last rising edge
  int          quiet_cycles = 0;
  int          mismatches = 0;

  function automatic void restart_image();
    int unsigned lv;
    for (lv = 0; lv < DEF_MAX_LEVELS; lv++) begin
      next_col[lv] = 0;
      next_row[lv] = 0;
    end
  endfunction

  function automatic void step_pos(int unsigned lv);
    next_col[lv]++;
    if (next_col[lv] >= (cur_w >> lv)) begin
      next_col[lv] = 0;
      next_row[lv]++;
      if (next_row[lv] >= (cur_h >> lv)) next_row[lv] = 0;
    end
  endfunction

  function automatic mip_px_t make_px(int unsigned lv, int unsigned c, int unsigned r,
                                      sums_t v);
    mip_px_t p;
    int ch;
    p = '0;
    p.level = lv[LEVEL_W-1:0];
    p.col = c[COORD_W-1:0];
    p.row = r[COORD_W-1:0];
    for (ch = 0; ch < NCH; ch++) p.px[ch] = v[ch][CH_W-1:0];
    return p;
  endfunction

  // Works out every item one base pixel causes, level 0 first.
  function automatic void predict_mip(pixel_t px);
    sums_t       val;
    sums_t       pair;
    mip_px_t     r;
    int unsigned x, y, w, h, idx, off, nlev, m, lv;
    logic        last_of_image;
    int          ch;
    x = next_col[0];
    y = next_row[0];
    last_of_image = (x == cur_w - 1) && (y == cur_h - 1);
    for (ch = 0; ch < NCH; ch++) val[ch] = {2'b00, px[ch]};
    r = make_px(0, x, y, val);
    step_pos(0);

    // floor(log2(longer side)) + 1 levels
    m = (cur_w > cur_h) ? cur_w : cur_h;
    nlev = 1;
    while (m > 1) begin
      m = m >> 1;
      nlev++;
    end
    if (nlev > DEF_MAX_LEVELS) nlev = DEF_MAX_LEVELS;

    off = 0;
    for (lv = 1; lv < nlev; lv++) begin
      w = cur_w >> lv;
      h = cur_h >> lv;
      if (w == 0 || h == 0) break;
      if (x >= 2 * w || y >= 2 * h) break;  // odd trailing column or row
      if (x % 2 == 0) begin
        left_px[lv] = val;
        break;
      end
      for (ch = 0; ch < NCH; ch++) pair[ch] = left_px[lv][ch] + val[ch];
      idx = off + x / 2;
      if (idx >= DEF_MAX_SIDE) break;
      if (y % 2 == 0) begin
        even_row_pairs[idx] = pair;
        break;
      end
      // bottom-right of a 2x2 block: truncated mean feeds the next level
      for (ch = 0; ch < NCH; ch++)
        val[ch] = {2'b00, 8'(((even_row_pairs[idx][ch] + pair[ch]) & 10'h3FF) >> 2)};
      mip_expected.push_back(r);
      x = next_col[lv];
      y = next_row[lv];
      r = make_px(lv, x, y, val);
      step_pos(lv);
      off += w;
    end
    r.last = 1'b1;
    r.done = last_of_image;
    mip_expected.push_back(r);
  endfunction

  function automatic string fmt_px(mip_px_t p);
    return $sformatf("L%0d (%0d,%0d) rgba %h %h %h %h pad %h last %b done %b",
                     p.level, p.col, p.row, p.px[0], p.px[1], p.px[2], p.px[3],
                     p.pad, p.last, p.done);
  endfunction

  // Random hold-off of one side according to the current idling phase.
  function automatic bit hold_off(bit sender);
    case (idle_mode)
      IDLE_SRC:  return sender && ($urandom_range(99) < 60);
      IDLE_SNK:  return !sender && ($urandom_range(99) < 60);
      IDLE_BOTH: return $urandom_range(99) < 13;
      default:   return 1'b0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: acceptance, prediction and the no-progress watchdog.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    pix_took <= !rst && s_tvalid && s_tready;
    if (!rst && s_tvalid && s_tready) predict_mip(s_tdata);
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_CYCLES) begin
      $display("box_filter_mipmap_chain_unit verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Driver: valid holds until the item is taken, then the next one or a gap.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || pix_took) begin
      if (pix_pending.size() != 0 && !hold_off(1'b1)) begin
        s_tdata  <= pix_pending.pop_front();
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure.
  always @(negedge clk) m_tready <= !rst && !hold_off(1'b0);

  // Monitor: each result item against the oldest expectation.
  always @(posedge clk) begin : result_check
    mip_px_t got;
    mip_px_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.level = m_tdata[3:0];
      got.col   = m_tdata[15:4];
      got.row   = m_tdata[27:16];
      got.px    = m_tdata[59:28];
      got.pad   = m_tdata[63:60];
      got.last  = m_tlast;
      got.done  = m_tuser;
      if (mip_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("unexpected result item: %s", fmt_px(got));
      end else begin
        want = mip_expected.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("result mismatch: expected %s, got %s", fmt_px(want), fmt_px(got));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Register write at a falling edge; the model follows right away since
  // writes only happen with nothing in flight.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SIDE_W-1:0] v);
    int unsigned s;
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    s = (v == 0) ? 1 : (v > DEF_MAX_SIDE) ? DEF_MAX_SIDE : v;
    if (idx == CFG_IMAGE_WIDTH) cur_w = s;
    else cur_h = s;
    restart_image();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_size(logic [SIDE_W-1:0] w, logic [SIDE_W-1:0] h);
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
  endtask

  // Sender holds off until every pending and expected item has gone through.
  task automatic settle();
    while (pix_pending.size() != 0 || s_tvalid || mip_expected.size() != 0)
      @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  initial begin : stimulus
    int unsigned w, h, n, sent, img, k;
    cur_w = RESET_SIDE;
    cur_h = RESET_SIDE;
    restart_image();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset size 256 x 256: first row only, level 0 plus held pixels
    pix_pending.push_back(32'h0000_0000);
    pix_pending.push_back(32'hFFFF_FFFF);
    pix_pending.push_back(32'h8040_2010);
    settle();

    // width 0 clamps to 1, height 8191 clamps to 4096: no level 1 column
    write_size(13'd0, 13'h1FFF);
    pix_pending.push_back(32'h0102_0408);
    pix_pending.push_back(32'hFEFD_FBF7);
    settle();

    // widest image, single row: no level 1 row
    write_size(13'd4096, 13'd1);
    pix_pending.push_back(32'h5555_5555);
    pix_pending.push_back(32'hAAAA_AAAA);
    settle();

    // 2 x 2 twice over: truncation, then full-scale sums, image end wraps
    write_size(13'd2, 13'd2);
    pix_pending.push_back(32'hFF03_0201);
    pix_pending.push_back(32'hFF00_0101);
    pix_pending.push_back(32'hFF00_0001);
    pix_pending.push_back(32'hFEFF_FF00);
    for (k = 0; k < 4; k++) pix_pending.push_back(32'hFFFF_FFFF);
    settle();

    // 3 x 2: trailing odd column dropped from level 1
    write_size(13'd3, 13'd2);
    for (k = 0; k < 6; k++) pix_pending.push_back($urandom());
    settle();

    // Random images, mostly whole ones; some wrap into a second image,
    // some are abandoned by a size write partway through.
    sent = 0;
    img = 0;
    while (sent < RANDOM_ITEMS) begin
      idle_mode = idle_mode_t'(img % 4);
      w = ($urandom_range(7) == 0) ? 16 : $urandom_range(1, 8);
      h = ($urandom_range(7) == 0) ? 16 : $urandom_range(1, 8);
      if (img > 0 && $urandom_range(4) == 0) begin
        write_reg(CFG_IMAGE_HEIGHT, h[SIDE_W-1:0]);
        w = cur_w;
      end else begin
        write_size(w[SIDE_W-1:0], h[SIDE_W-1:0]);
      end
      n = w * h;
      if ($urandom_range(3) == 0) n = 2 * n;
      else if (n > 1 && $urandom_range(4) == 0) n = $urandom_range(1, n - 1);
      if (n > 128) n = 128;
      if (n > RANDOM_ITEMS - sent) n = RANDOM_ITEMS - sent;
      for (k = 0; k < n; k++) pix_pending.push_back($urandom());
      sent += n;
      img++;
      settle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && mip_expected.size() == 0) begin
      $display("box_filter_mipmap_chain_unit verification clean");
    end else begin
      $display("box_filter_mipmap_chain_unit verification failed");
    end
    $finish;
  end

endmodule
